### rtl/utf8_validating_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 validating decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATING_DECODER_UNIT_MACROS_SVH
`define UTF8_VALIDATING_DECODER_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define UVD_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define UVD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define UVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/utf8vd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder package
// Types, status codes and limits shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8vd_pkg;

   localparam int unsigned BYTE_LIMIT_BOUND  = 1048576;
   localparam int unsigned POINT_LIMIT_BOUND = 262144;

   localparam int unsigned BYTE_CNT_W  = 21;
   localparam int unsigned POINT_CNT_W = 19;
   localparam int unsigned SCALAR_W    = 21;
   localparam int unsigned OFFSET_W    = 20;
   localparam int unsigned CSR_DATA_W  = 21;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned RSP_DATA_W  = 64;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [SCALAR_W-1:0] SCALAR_MAX     = 21'h10FFFF;
   localparam logic [SCALAR_W-1:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [SCALAR_W-1:0] SURROGATE_HI   = 21'h00DFFF;
   localparam logic [SCALAR_W-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [SCALAR_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [SCALAR_W-1:0] MIN_FOUR_BYTE  = 21'h010000;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TEXT_BYTES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CODEPOINTS = 1'b1;

   localparam logic KIND_CODEPOINT = 1'b0;
   localparam logic KIND_STATUS    = 1'b1;

   typedef enum logic [2:0] {
      ST_OK              = 3'd0,
      ST_TOO_MANY_BYTES  = 3'd1,
      ST_TOO_MANY_POINTS = 3'd2,
      ST_BAD_LEAD        = 3'd3,
      ST_TRUNCATED       = 3'd4,
      ST_BAD_CONT        = 3'd5,
      ST_NON_SCALAR      = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       text_end;
   } req_item_type;

   // results caused by one input word: optional codepoint, then optional status
   typedef struct packed {
      logic                   cp_valid;
      logic                   end_valid;
      logic [SCALAR_W-1:0]    scalar_value;
      logic [OFFSET_W-1:0]    lead_offset;
      status_type             status;
      logic [POINT_CNT_W-1:0] total_codepoints;
   } entry_type;

endpackage

### rtl/utf8_validating_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder unit
// Streams text bytes in, codepoints and an end-of-text status out.
// ----------------------------------------------------------------------------
// One word is taken per clock while the four-entry result queue has room. A
// word is registered in the input register, decoded from there once the
// queue has room, and its results are queued and then offered on rsp_ from
// the queue head. The queue drains one result per cycle through rsp_ while
// rsp_tready is high, so a word that causes both a codepoint and a status
// is sent as two results, the codepoint first. No clearing pass is needed
// after reset.
`timescale 1ns / 1ps
`include "utf8_validating_decoder_unit_macros.svh"

module utf8_validating_decoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // input words
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tuser,  // byte_present
   input  logic                                  req_tlast,  // text_end
   // result words
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [20:0] scalar_value, [40:21] lead_offset, [43:41] status,
   // [62:44] total_codepoints, [63] zero
   output logic [utf8vd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,  // result_kind
   output logic                                  rsp_tlast,  // last_of_run
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [utf8vd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [utf8vd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import utf8vd_pkg::*;

   localparam logic [BYTE_CNT_W-1:0]  BYTE_LIM_RESET  = BYTE_CNT_W'(BYTE_LIMIT_BOUND);
   localparam logic [POINT_CNT_W-1:0] POINT_LIM_RESET = POINT_CNT_W'(POINT_LIMIT_BOUND);
   localparam logic [FIFO_AW:0]       FIFO_FULL       = (FIFO_AW+1)'(FIFO_DEPTH);

   logic [BYTE_CNT_W-1:0]  byte_lim_ff;
   logic [POINT_CNT_W-1:0] point_lim_ff;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         fire;
   entry_type    ent;

   entry_type          fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;
   logic               sub_ff, sub_in;
   logic               push, pop, rsp_fire, show_cp;
   entry_type          head;

   // configuration, clamped to the supported bounds on write (the codepoint limit after truncation to POINT_CNT_W bits)
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_lim_ff  <= BYTE_LIM_RESET;
         point_lim_ff <= POINT_LIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_TEXT_BYTES: begin
               byte_lim_ff <= (csr_wr_data > BYTE_LIM_RESET) ? BYTE_LIM_RESET : csr_wr_data;
            end
            CSR_MAX_CODEPOINTS: begin
               point_lim_ff <= (csr_wr_data[POINT_CNT_W-1:0] > POINT_LIM_RESET)
                               ? POINT_LIM_RESET : csr_wr_data[POINT_CNT_W-1:0];
            end
            default: begin
               byte_lim_ff <= byte_lim_ff;
            end
         endcase
      end
   end

   // input register
   assign fire        = in_valid_ff && (cnt_ff < FIFO_FULL);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= '{data_byte: req_tdata, byte_present: req_tuser, text_end: req_tlast};
      end
   end

   utf8vd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .byte_lim  (byte_lim_ff),
      .point_lim (point_lim_ff),
      .ent       (ent)
   );

   // result queue, one entry per word that has results
   assign push     = fire && (ent.cp_valid || ent.end_valid);
   assign head     = fifo_ff[rd_ptr_ff];
   assign show_cp  = head.cp_valid && !sub_ff;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign pop      = rsp_fire && rsp_tlast;
   assign cnt_in   = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   assign sub_in   = pop ? 1'b0 : (rsp_fire ? 1'b1 : sub_ff);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
         rd_ptr_ff <= pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
         cnt_ff    <= cnt_in;
         sub_ff    <= sub_in;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = show_cp ? KIND_CODEPOINT : KIND_STATUS;
   assign rsp_tlast  = !show_cp || !head.end_valid;
   assign rsp_tdata  = show_cp
      ? {1'b0, POINT_CNT_W'(0), ST_OK, head.lead_offset, head.scalar_value}
      : {1'b0, head.total_codepoints, head.status, OFFSET_W'(0), SCALAR_W'(0)};

   `UVD_ASSERT_HOLDS(a_fifo_bound, clock, reset, cnt_ff <= FIFO_FULL, "result queue overflow")
   `UVD_ASSERT_NEXT(a_status_follows, clock, reset, rsp_fire && !rsp_tlast, rsp_tvalid && (rsp_tuser == KIND_STATUS) && rsp_tlast, "status must follow codepoint of same word")
   `UVD_ASSERT_IMPLIES(a_scalar_legal, clock, reset, rsp_tvalid && (rsp_tuser == KIND_CODEPOINT), (rsp_tdata[20:0] <= SCALAR_MAX) && ((rsp_tdata[20:0] < SURROGATE_LO) || (rsp_tdata[20:0] > SURROGATE_HI)), "emitted value is not a scalar")

endmodule

### rtl/utf8vd_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds per-text state and turns one input word into its result entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_validating_decoder_unit_macros.svh"

module utf8vd_decode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  utf8vd_pkg::req_item_type           item,
   input  logic [utf8vd_pkg::BYTE_CNT_W-1:0]  byte_lim,
   input  logic [utf8vd_pkg::POINT_CNT_W-1:0] point_lim,
   output utf8vd_pkg::entry_type              ent
);
   import utf8vd_pkg::*;

   localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX = '1;

   logic [BYTE_CNT_W-1:0]  byte_cnt_ff, byte_cnt_in;
   logic [POINT_CNT_W-1:0] pt_cnt_ff, pt_cnt_in;
   logic [1:0]             rem_ff, rem_in;
   logic [2:0]             len_ff, len_in;
   logic [SCALAR_W-1:0]    acc_ff, acc_in;
   logic [OFFSET_W-1:0]    start_ff, start_in;
   logic                   pend_ff, pend_in;
   status_type             fault_ff, fault_in;

   always_comb begin
      logic                emit;
      logic                lead;
      logic [SCALAR_W-1:0] minimum;
      logic [7:0]          b;

      b           = item.data_byte;
      emit        = 1'b0;
      lead        = 1'b0;
      minimum     = MIN_FOUR_BYTE;
      byte_cnt_in = byte_cnt_ff;
      pt_cnt_in   = pt_cnt_ff;
      rem_in      = rem_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      start_in    = start_ff;
      pend_in     = pend_ff;
      fault_in    = fault_ff;
      ent         = '0;
      ent.status  = ST_OK;

      if (fire && item.byte_present) begin
         if (byte_cnt_ff != BYTE_CNT_MAX) begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
         end
         if (byte_cnt_ff >= byte_lim) begin
            fault_in = ST_TOO_MANY_BYTES;
         end else if (fault_ff != ST_OK) begin
            fault_in = fault_ff;
         end else if (rem_ff == 2'd0) begin
            if (pt_cnt_ff >= point_lim) begin
               fault_in = ST_TOO_MANY_POINTS;
            end else begin
               case (b) inside
                  [8'h00:8'h7F]: begin
                     emit             = 1'b1;
                     ent.scalar_value = SCALAR_W'(b);
                     ent.lead_offset  = byte_cnt_ff[OFFSET_W-1:0];
                  end
                  [8'hC0:8'hDF]: begin
                     lead   = 1'b1;
                     len_in = 3'd2;
                     acc_in = SCALAR_W'(b[4:0]);
                  end
                  [8'hE0:8'hEF]: begin
                     lead   = 1'b1;
                     len_in = 3'd3;
                     acc_in = SCALAR_W'(b[3:0]);
                  end
                  [8'hF0:8'hF7]: begin
                     lead   = 1'b1;
                     len_in = 3'd4;
                     acc_in = SCALAR_W'(b[2:0]);
                  end
                  default: begin
                     fault_in = ST_BAD_LEAD;
                  end
               endcase
            end
            if (lead) begin
               rem_in   = 2'(len_in - 3'd1);
               start_in = byte_cnt_ff[OFFSET_W-1:0];
               pend_in  = 1'b0;
            end
         end else begin
            if (b[7:6] != 2'b10) begin
               pend_in = 1'b1;
            end else begin
               acc_in = {acc_ff[SCALAR_W-7:0], b[5:0]};
            end
            rem_in = rem_ff - 2'd1;
            if (rem_in == 2'd0) begin
               case (len_ff)
                  3'd2:    minimum = MIN_TWO_BYTE;
                  3'd3:    minimum = MIN_THREE_BYTE;
                  default: minimum = MIN_FOUR_BYTE;
               endcase
               if (pend_in) begin
                  fault_in = ST_BAD_CONT;
               end else if (acc_in < minimum || acc_in > SCALAR_MAX ||
                            (acc_in >= SURROGATE_LO && acc_in <= SURROGATE_HI)) begin
                  fault_in = ST_NON_SCALAR;
               end else begin
                  emit             = 1'b1;
                  ent.scalar_value = acc_in;
                  ent.lead_offset  = start_ff;
               end
               pend_in = 1'b0;
            end
         end
         if (emit) begin
            pt_cnt_in = pt_cnt_ff + 1'b1;
         end
         ent.cp_valid = emit;
      end

      if (fire && item.text_end) begin
         ent.end_valid        = 1'b1;
         ent.status           = (fault_in == ST_OK && rem_in != 2'd0) ? ST_TRUNCATED
                                                                      : fault_in;
         ent.total_codepoints = pt_cnt_in;
         byte_cnt_in          = '0;
         pt_cnt_in            = '0;
         rem_in               = '0;
         len_in               = '0;
         acc_in               = '0;
         start_in             = '0;
         pend_in              = 1'b0;
         fault_in             = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         pt_cnt_ff   <= '0;
         rem_ff      <= '0;
         len_ff      <= '0;
         acc_ff      <= '0;
         start_ff    <= '0;
         pend_ff     <= 1'b0;
         fault_ff    <= ST_OK;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         pt_cnt_ff   <= pt_cnt_in;
         rem_ff      <= rem_in;
         len_ff      <= len_in;
         acc_ff      <= acc_in;
         start_ff    <= start_in;
         pend_ff     <= pend_in;
         fault_ff    <= fault_in;
      end
   end

   `UVD_ASSERT_IMPLIES(a_rem_within_len, clock, reset, rem_ff != 2'd0, (len_ff >= 3'd2) && (3'(rem_ff) < len_ff), "continuation count exceeds sequence length")
   `UVD_ASSERT_NEXT(a_end_clears, clock, reset, fire && item.text_end, (byte_cnt_ff == '0) && (pt_cnt_ff == '0) && (fault_ff == ST_OK) && (rem_ff == 2'd0), "text state not cleared after end")
   `UVD_ASSERT_IMPLIES(a_cp_needs_byte, clock, reset, ent.cp_valid, fire && item.byte_present && (pt_cnt_ff < point_lim), "codepoint without byte or over limit")

endmodule
